// ----- rtl/core/cc20_pkg.sv -----
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared widths, types, register codes and controller encoding for the
// ChaCha20 stream cipher core.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned TEXT_W     = 64;
  localparam int unsigned NUM_TEXT   = 8;
  localparam int unsigned NUM_WORDS  = 16;
  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  typedef logic [WORD_W-1:0]     word_t;
  typedef logic [TEXT_W-1:0]     text_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // "expand 32-byte k"
  localparam word_t SIGMA_0 = 32'h6170_7865;
  localparam word_t SIGMA_1 = 32'h3320_646e;
  localparam word_t SIGMA_2 = 32'h7962_2d32;
  localparam word_t SIGMA_3 = 32'h6b20_6574;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_01   = 3'd0,
    CFG_KEY_23   = 3'd1,
    CFG_KEY_45   = 3'd2,
    CFG_KEY_67   = 3'd3,
    CFG_NONCE_01 = 3'd4,
    CFG_NONCE_2  = 3'd5,
    CFG_INIT_CTR = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    text_t [NUM_TEXT-1:0] text_word;
    count_t               byte_count;
    logic                 restart;
  } in_item_t;

  typedef struct packed {
    text_t [NUM_TEXT-1:0] out_word;
    count_t               out_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic round;
    logic diag;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

// ----- rtl/core/cc20_ifs.sv -----
// ----------------------------------------------------------------------------
// cc20 channel interfaces
// Valid/ready channels for text items, result items and register writes.
// ----------------------------------------------------------------------------
interface cc20_in_if;
  import cc20_pkg::*;

  logic   valid;
  logic   ready;
  text_t  text_word_0;
  text_t  text_word_1;
  text_t  text_word_2;
  text_t  text_word_3;
  text_t  text_word_4;
  text_t  text_word_5;
  text_t  text_word_6;
  text_t  text_word_7;
  count_t byte_count;
  logic   restart;

  modport source (
    output valid, text_word_0, text_word_1, text_word_2, text_word_3,
    output text_word_4, text_word_5, text_word_6, text_word_7,
    output byte_count, restart,
    input  ready
  );

  modport sink (
    input  valid, text_word_0, text_word_1, text_word_2, text_word_3,
    input  text_word_4, text_word_5, text_word_6, text_word_7,
    input  byte_count, restart,
    output ready
  );
endinterface

interface cc20_out_if;
  import cc20_pkg::*;

  logic   valid;
  logic   ready;
  text_t  out_word_0;
  text_t  out_word_1;
  text_t  out_word_2;
  text_t  out_word_3;
  text_t  out_word_4;
  text_t  out_word_5;
  text_t  out_word_6;
  text_t  out_word_7;
  count_t out_count;

  modport source (
    output valid, out_word_0, out_word_1, out_word_2, out_word_3,
    output out_word_4, out_word_5, out_word_6, out_word_7, out_count,
    input  ready
  );

  modport sink (
    input  valid, out_word_0, out_word_1, out_word_2, out_word_3,
    input  out_word_4, out_word_5, out_word_6, out_word_7, out_count,
    output ready
  );
endinterface

interface cc20_cfg_if;
  import cc20_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/chacha20_stream_cipher_core.sv -----
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_core
// ChaCha20 (RFC 8439) block cipher core: xors one 64-byte text block per
// item with one keystream block and keeps the 32-bit block counter.
// ----------------------------------------------------------------------------
// One item is one 64-byte block. After it is taken the core runs one round
// per cycle on four parallel quarter-round units, 2*DOUBLE_ROUNDS rounds in
// all (ten double rounds by default); once the output register is free it
// does the feed-forward, xor and byte masking, writes the output register
// and only then takes the next item. Most of the time per item goes into
// the round loop. The output register holds a finished result while the
// next item is already being worked on; the core only waits when a second
// result is ready and the first has not been taken. Key, nonce and initial
// counter registers are written through the configuration channel (index 0
// to 6, others ignored); the user must write them only while the core is
// idle, the core itself does not enforce this. The block counter resets to
// zero, is reloaded from initial_counter when an item has restart set, is
// used for that block and then advances, wrapping at 2^32 without carry
// into the nonce. Bytes at or past byte_count come out as zero; out_count
// repeats byte_count as given.
module chacha20_stream_cipher_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input logic         clk_i,
  input logic         rst_ni,
  cc20_cfg_if.sink    cfg_i,
  cc20_in_if.sink     in_i,
  cc20_out_if.source  out_o
);
  import cc20_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   in_item;
  out_item_t  out_item;
  logic       in_ready;
  logic       out_valid;

  // register writes are always accepted
  assign cfg_i.ready = 1'b1;

  // gather the item fields into one word for the datapath
  assign in_item.text_word[0] = in_i.text_word_0;
  assign in_item.text_word[1] = in_i.text_word_1;
  assign in_item.text_word[2] = in_i.text_word_2;
  assign in_item.text_word[3] = in_i.text_word_3;
  assign in_item.text_word[4] = in_i.text_word_4;
  assign in_item.text_word[5] = in_i.text_word_5;
  assign in_item.text_word[6] = in_i.text_word_6;
  assign in_item.text_word[7] = in_i.text_word_7;
  assign in_item.byte_count   = in_i.byte_count;
  assign in_item.restart      = in_i.restart;

  assign in_i.ready = in_ready;

  // sequencer: idle, rounds, commit
  cc20_ctrl #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // state, quarter-round units and output register
  cc20_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid),
    .out_ready_i (out_o.ready),
    .out_item_o  (out_item)
  );

  // scatter the result back onto the channel fields
  assign out_o.valid      = out_valid;
  assign out_o.out_word_0 = out_item.out_word[0];
  assign out_o.out_word_1 = out_item.out_word[1];
  assign out_o.out_word_2 = out_item.out_word[2];
  assign out_o.out_word_3 = out_item.out_word[3];
  assign out_o.out_word_4 = out_item.out_word[4];
  assign out_o.out_word_5 = out_item.out_word[5];
  assign out_o.out_word_6 = out_item.out_word[6];
  assign out_o.out_word_7 = out_item.out_word[7];
  assign out_o.out_count  = out_item.out_count;

endmodule

// ----- rtl/core/cc20_qr.sv -----
// ----------------------------------------------------------------------------
// cc20_qr
// One ChaCha quarter-round on four 32-bit words.
// ----------------------------------------------------------------------------
module cc20_qr (
  input  cc20_pkg::word_t a_i,
  input  cc20_pkg::word_t b_i,
  input  cc20_pkg::word_t c_i,
  input  cc20_pkg::word_t d_i,
  output cc20_pkg::word_t a_o,
  output cc20_pkg::word_t b_o,
  output cc20_pkg::word_t c_o,
  output cc20_pkg::word_t d_o
);
  import cc20_pkg::*;

  word_t a1, b1, c1, d1;
  word_t a2, b2, c2, d2;
  word_t dx1, bx1, dx2, bx2;

  assign a1  = a_i + b_i;
  assign dx1 = d_i ^ a1;
  assign d1  = {dx1[15:0], dx1[31:16]};
  assign c1  = c_i + d1;
  assign bx1 = b_i ^ c1;
  assign b1  = {bx1[19:0], bx1[31:20]};
  assign a2  = a1 + b1;
  assign dx2 = d1 ^ a2;
  assign d2  = {dx2[23:0], dx2[31:24]};
  assign c2  = c1 + d2;
  assign bx2 = b1 ^ c2;
  assign b2  = {bx2[24:0], bx2[31:25]};

  assign a_o = a2;
  assign b_o = b2;
  assign c_o = c2;
  assign d_o = d2;

endmodule

// ----- rtl/core/cc20_ctrl.sv -----
// ----------------------------------------------------------------------------
// cc20_ctrl
// Sequencer: takes an item, steps the round datapath, then commits the
// result into the output register.
// ----------------------------------------------------------------------------
module cc20_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cc20_pkg::dp_status_t status_i,
  output cc20_pkg::dp_cmd_t    cmd_o
);
  import cc20_pkg::*;

  localparam int unsigned NUM_ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int unsigned RND_W      = $clog2(NUM_ROUNDS);
  localparam logic [RND_W-1:0] LAST_RND = RND_W'(NUM_ROUNDS - 1);

  ctrl_state_e      state_q, state_d;
  logic [RND_W-1:0] rnd_q, rnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    rnd_d      = rnd_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          rnd_d      = '0;
          state_d    = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.round = 1'b1;
        // even rounds are column rounds, odd ones diagonal
        cmd_o.diag  = rnd_q[0];
        if (rnd_q == LAST_RND) begin
          state_d = ST_FINISH;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/cc20_datapath.sv -----
// ----------------------------------------------------------------------------
// cc20_datapath
// Key/nonce registers, block counter, 16-word working state with four
// quarter-round units, feed-forward, text xor and the output register.
// ----------------------------------------------------------------------------
module cc20_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  cc20_pkg::cfg_idx_t   cfg_idx_i,
  input  cc20_pkg::cfg_data_t  cfg_data_i,
  input  cc20_pkg::in_item_t   in_item_i,
  input  cc20_pkg::dp_cmd_t    cmd_i,
  output cc20_pkg::dp_status_t status_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output cc20_pkg::out_item_t  out_item_o
);
  import cc20_pkg::*;

  // word positions of the four quarter-rounds
  localparam logic [3:0] QR_A  [4] = '{4'd0,  4'd1,  4'd2,  4'd3};
  localparam logic [3:0] COL_B [4] = '{4'd4,  4'd5,  4'd6,  4'd7};
  localparam logic [3:0] COL_C [4] = '{4'd8,  4'd9,  4'd10, 4'd11};
  localparam logic [3:0] COL_D [4] = '{4'd12, 4'd13, 4'd14, 4'd15};
  localparam logic [3:0] DIA_B [4] = '{4'd5,  4'd6,  4'd7,  4'd4};
  localparam logic [3:0] DIA_C [4] = '{4'd10, 4'd11, 4'd8,  4'd9};
  localparam logic [3:0] DIA_D [4] = '{4'd15, 4'd12, 4'd13, 4'd14};

  text_t [3:0]          key_q;
  text_t                nonce01_q;
  word_t                nonce2_q;
  word_t                ctr_init_q;
  word_t                blk_ctr_q, blk_ctr_d;
  word_t                ctr_start;

  word_t [NUM_WORDS-1:0] init_s;
  word_t [NUM_WORDS-1:0] work_q, work_d;
  word_t [NUM_WORDS-1:0] ks_s;
  text_t [NUM_TEXT-1:0]  ks_text;
  text_t [NUM_TEXT-1:0]  text_q;
  count_t                count_q;

  logic [3:0] idx_b [4];
  logic [3:0] idx_c [4];
  logic [3:0] idx_d [4];
  word_t      qa_i [4];
  word_t      qb_i [4];
  word_t      qc_i [4];
  word_t      qd_i [4];
  word_t      qa_o [4];
  word_t      qb_o [4];
  word_t      qc_o [4];
  word_t      qd_o [4];

  logic      out_valid_q;
  out_item_t out_q;
  out_item_t res_s;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q      <= '0;
      nonce01_q  <= '0;
      nonce2_q   <= '0;
      ctr_init_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_KEY_01:   key_q[0]   <= cfg_data_i;
        CFG_KEY_23:   key_q[1]   <= cfg_data_i;
        CFG_KEY_45:   key_q[2]   <= cfg_data_i;
        CFG_KEY_67:   key_q[3]   <= cfg_data_i;
        CFG_NONCE_01: nonce01_q  <= cfg_data_i;
        CFG_NONCE_2:  nonce2_q   <= cfg_data_i[WORD_W-1:0];
        CFG_INIT_CTR: ctr_init_q <= cfg_data_i[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    init_s[0]  = SIGMA_0;
    init_s[1]  = SIGMA_1;
    init_s[2]  = SIGMA_2;
    init_s[3]  = SIGMA_3;
    init_s[4]  = key_q[0][31:0];
    init_s[5]  = key_q[0][63:32];
    init_s[6]  = key_q[1][31:0];
    init_s[7]  = key_q[1][63:32];
    init_s[8]  = key_q[2][31:0];
    init_s[9]  = key_q[2][63:32];
    init_s[10] = key_q[3][31:0];
    init_s[11] = key_q[3][63:32];
    init_s[12] = blk_ctr_q;
    init_s[13] = nonce01_q[31:0];
    init_s[14] = nonce01_q[63:32];
    init_s[15] = nonce2_q;
  end

  assign ctr_start = in_item_i.restart ? ctr_init_q : blk_ctr_q;

  for (genvar k = 0; k < 4; k++) begin : g_qr
    assign idx_b[k] = cmd_i.diag ? DIA_B[k] : COL_B[k];
    assign idx_c[k] = cmd_i.diag ? DIA_C[k] : COL_C[k];
    assign idx_d[k] = cmd_i.diag ? DIA_D[k] : COL_D[k];
    assign qa_i[k]  = work_q[QR_A[k]];
    assign qb_i[k]  = work_q[idx_b[k]];
    assign qc_i[k]  = work_q[idx_c[k]];
    assign qd_i[k]  = work_q[idx_d[k]];

    cc20_qr u_qr (
      .a_i (qa_i[k]),
      .b_i (qb_i[k]),
      .c_i (qc_i[k]),
      .d_i (qd_i[k]),
      .a_o (qa_o[k]),
      .b_o (qb_o[k]),
      .c_o (qc_o[k]),
      .d_o (qd_o[k])
    );
  end

  always_comb begin
    work_d    = work_q;
    blk_ctr_d = blk_ctr_q;
    if (cmd_i.load) begin
      work_d     = init_s;
      work_d[12] = ctr_start;
      blk_ctr_d  = ctr_start;
    end else if (cmd_i.round) begin
      for (int k = 0; k < 4; k++) begin
        work_d[QR_A[k]]  = qa_o[k];
        work_d[idx_b[k]] = qb_o[k];
        work_d[idx_c[k]] = qc_o[k];
        work_d[idx_d[k]] = qd_o[k];
      end
    end else if (cmd_i.finish) begin
      blk_ctr_d = blk_ctr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_ctr_q <= '0;
    end else begin
      blk_ctr_q <= blk_ctr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    if (cmd_i.load) begin
      text_q  <= in_item_i.text_word;
      count_q <= in_item_i.byte_count;
    end
  end

  // feed-forward, xor, zero the bytes past the count
  for (genvar w = 0; w < NUM_TEXT; w++) begin : g_res
    assign ks_s[2*w]   = work_q[2*w]   + init_s[2*w];
    assign ks_s[2*w+1] = work_q[2*w+1] + init_s[2*w+1];
    assign ks_text[w]  = {ks_s[2*w+1], ks_s[2*w]};
    for (genvar b = 0; b < 8; b++) begin : g_byte
      assign res_s.out_word[w][8*b +: 8] =
        (count_q > COUNT_W'(8*w + b)) ?
        (text_q[w][8*b +: 8] ^ ks_text[w][8*b +: 8]) : 8'h00;
    end
  end
  assign res_s.out_count = count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_q <= res_s;
    end
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign out_item_o        = out_q;

endmodule

// ----- rtl/core/cc20_checker.sv -----
// ----------------------------------------------------------------------------
// cc20_checker
// Port-level checks for the ChaCha20 core, bound to the top level.
// ----------------------------------------------------------------------------
module cc20_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input cc20_pkg::text_t   out_word_0_i,
  input cc20_pkg::count_t  out_count_i
);
  import cc20_pkg::*;

  logic in_acc;
  logic out_stall;

  assign in_acc    = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;

  // one item at a time: no new item right after one is taken
  a_one_at_a_time: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i
  ) else $error("item taken while previous item still in rounds");

  // a result only shows up at the end of a busy phase
  a_result_after_work: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_ready_i)
  ) else $error("result appeared without a block being worked on");

  // a stalled result holds
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_stall |=> out_valid_i && $stable(out_word_0_i) && $stable(out_count_i)
  ) else $error("stalled result changed or dropped");

endmodule

bind chacha20_stream_cipher_core cc20_checker u_cc20_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_word_0_i (out_o.out_word_0),
  .out_count_i  (out_o.out_count)
);

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for chacha20_stream_cipher_core: random and directed
// text blocks go in under bursty valid and stalling ready, and every result
// is compared field by field against a cycle-free ChaCha20 predictor.
// ----------------------------------------------------------------------------
module tb;
  import cc20_pkg::*;

  localparam int unsigned DOUBLE_ROUNDS = 10;
  localparam int unsigned CLK_HALF      = 5;
  localparam int unsigned RESET_CYCLES  = 9;
  // settling time after the last result, for any work still in flight
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned PHASE_ITEMS   = 250;
  localparam int unsigned NUM_PHASES    = 7;
  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned FULL_BLOCK    = 64;
  // no register sits at this index, writes to it must be dropped
  localparam cfg_idx_t    CFG_UNUSED    = 3'd7;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_PATTERN,
    RX_MOSTLY
  } rx_mode_e;

  typedef enum logic [1:0] {
    SET_RANDOM,
    SET_ZEROS,
    SET_ONES,
    SET_WRAP
  } setting_e;

  logic clk_i;
  logic rst_ni;

  cc20_cfg_if cfg_if ();
  cc20_in_if  in_if ();
  cc20_out_if out_if ();

  chacha20_stream_cipher_core #(
    .DOUBLE_ROUNDS(DOUBLE_ROUNDS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // --------------------------------------------------------------------------
  // clock
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // predictor state: shadow copy of the cipher registers and block counter
  // --------------------------------------------------------------------------
  cfg_data_t key_reg [4];
  cfg_data_t nonce01_reg;
  word_t     nonce2_reg;
  word_t     init_ctr_reg;
  word_t     blk_ctr;

  in_item_t  pending_text_q [$];
  out_item_t expected_cipher_q [$];

  int unsigned mismatches;
  int unsigned hold_req;
  int unsigned hold_seen;

  // handshakes seen at the last rising edge, used by the falling-edge drivers
  logic in_took;
  logic cfg_took;

  function automatic word_t rotl(input word_t v, input int unsigned n);
    return (v << n) | (v >> (WORD_W - n));
  endfunction

  function automatic void quarter_round(inout word_t a, inout word_t b,
                                        inout word_t c, inout word_t d);
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
  endfunction

  // one keystream block for the given counter under the current key and nonce
  function automatic void keystream_block(input word_t ctr, output word_t ks [NUM_WORDS]);
    word_t base [NUM_WORDS];
    word_t x [NUM_WORDS];
    base[0] = SIGMA_0;
    base[1] = SIGMA_1;
    base[2] = SIGMA_2;
    base[3] = SIGMA_3;
    for (int i = 0; i < 4; i++) begin
      base[4 + 2 * i] = key_reg[i][31:0];
      base[5 + 2 * i] = key_reg[i][63:32];
    end
    base[12] = ctr;
    base[13] = nonce01_reg[31:0];
    base[14] = nonce01_reg[63:32];
    base[15] = nonce2_reg;
    x = base;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      // columns
      quarter_round(x[0], x[4], x[8],  x[12]);
      quarter_round(x[1], x[5], x[9],  x[13]);
      quarter_round(x[2], x[6], x[10], x[14]);
      quarter_round(x[3], x[7], x[11], x[15]);
      // diagonals
      quarter_round(x[0], x[5], x[10], x[15]);
      quarter_round(x[1], x[6], x[11], x[12]);
      quarter_round(x[2], x[7], x[8],  x[13]);
      quarter_round(x[3], x[4], x[9],  x[14]);
    end
    for (int i = 0; i < NUM_WORDS; i++) ks[i] = x[i] + base[i];
  endfunction

  // expected cipher block for one accepted text block, advances the counter
  function automatic out_item_t encrypt_block(input in_item_t it);
    out_item_t   res;
    word_t       ks [NUM_WORDS];
    text_t       mask;
    int unsigned nbytes;
    int unsigned first;
    if (it.restart) blk_ctr = init_ctr_reg;
    keystream_block(blk_ctr, ks);
    blk_ctr = blk_ctr + 1;
    // counts above a full block still mean a full block
    nbytes = (it.byte_count > FULL_BLOCK) ? FULL_BLOCK : it.byte_count;
    for (int w = 0; w < NUM_TEXT; w++) begin
      first = 8 * w;
      if (nbytes >= first + 8) mask = '1;
      else if (nbytes <= first) mask = '0;
      else mask = (text_t'(1) << (8 * (nbytes - first))) - text_t'(1);
      res.out_word[w] = (it.text_word[w] ^ {ks[2 * w + 1], ks[2 * w]}) & mask;
    end
    res.out_count = it.byte_count;
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // text driver: bursts of random length, random gaps in between
  // --------------------------------------------------------------------------
  in_item_t    nxt_text;
  int unsigned burst_left;
  int unsigned gap_left;

  always @(negedge clk_i) begin
    if (rst_ni && (!in_if.valid || in_took)) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_text_q.size() > 0) begin
        nxt_text = pending_text_q.pop_front();
        in_if.text_word_0 <= nxt_text.text_word[0];
        in_if.text_word_1 <= nxt_text.text_word[1];
        in_if.text_word_2 <= nxt_text.text_word[2];
        in_if.text_word_3 <= nxt_text.text_word[3];
        in_if.text_word_4 <= nxt_text.text_word[4];
        in_if.text_word_5 <= nxt_text.text_word[5];
        in_if.text_word_6 <= nxt_text.text_word[6];
        in_if.text_word_7 <= nxt_text.text_word[7];
        in_if.byte_count  <= nxt_text.byte_count;
        in_if.restart     <= nxt_text.restart;
        in_if.valid       <= 1'b1;
        if (burst_left <= 1) begin
          // new burst; about half the gaps are zero so long busy runs occur
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left = burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result receiver: ready follows a changing stall mode, plus long holds
  // --------------------------------------------------------------------------
  rx_mode_e    rx_mode;
  int unsigned rx_mode_left;
  int unsigned hold_left;
  logic [31:0] rx_pattern;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        // long hold-off: the core fills up and must stall its input
        hold_left = hold_left - 1;
        out_if.ready <= 1'b0;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode      = rx_mode_e'($urandom_range(0, 3));
          rx_mode_left = $urandom_range(20, 200);
          rx_pattern   = $urandom;
        end
        rx_mode_left = rx_mode_left - 1;
        case (rx_mode)
          RX_OPEN:    out_if.ready <= 1'b1;
          RX_COIN:    out_if.ready <= $urandom_range(0, 1);
          RX_PATTERN: begin
            out_if.ready <= rx_pattern[0];
            rx_pattern = {rx_pattern[0], rx_pattern[31:1]};
          end
          default:    out_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // monitors: accepted text items feed the predictor, results are checked
  // --------------------------------------------------------------------------
  in_item_t  seen_text;
  out_item_t seen_cipher;
  out_item_t want_cipher;

  always @(posedge clk_i) begin
    in_took  <= rst_ni && in_if.valid && in_if.ready;
    cfg_took <= rst_ni && cfg_if.valid && cfg_if.ready;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      seen_text.text_word[0] = in_if.text_word_0;
      seen_text.text_word[1] = in_if.text_word_1;
      seen_text.text_word[2] = in_if.text_word_2;
      seen_text.text_word[3] = in_if.text_word_3;
      seen_text.text_word[4] = in_if.text_word_4;
      seen_text.text_word[5] = in_if.text_word_5;
      seen_text.text_word[6] = in_if.text_word_6;
      seen_text.text_word[7] = in_if.text_word_7;
      seen_text.byte_count   = in_if.byte_count;
      seen_text.restart      = in_if.restart;
      expected_cipher_q.push_back(encrypt_block(seen_text));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      seen_cipher.out_word[0] = out_if.out_word_0;
      seen_cipher.out_word[1] = out_if.out_word_1;
      seen_cipher.out_word[2] = out_if.out_word_2;
      seen_cipher.out_word[3] = out_if.out_word_3;
      seen_cipher.out_word[4] = out_if.out_word_4;
      seen_cipher.out_word[5] = out_if.out_word_5;
      seen_cipher.out_word[6] = out_if.out_word_6;
      seen_cipher.out_word[7] = out_if.out_word_7;
      seen_cipher.out_count   = out_if.out_count;
      if (expected_cipher_q.size() == 0) begin
        mismatches++;
        $error("unexpected result item, out_word_0 %h", seen_cipher.out_word[0]);
      end else begin
        want_cipher = expected_cipher_q.pop_front();
        for (int w = 0; w < NUM_TEXT; w++) begin
          if (seen_cipher.out_word[w] !== want_cipher.out_word[w]) begin
            mismatches++;
            $error("out_word_%0d: expected %h, got %h", w,
                   want_cipher.out_word[w], seen_cipher.out_word[w]);
          end
        end
        if (seen_cipher.out_count !== want_cipher.out_count) begin
          mismatches++;
          $error("out_count: expected %0d, got %0d",
                 want_cipher.out_count, seen_cipher.out_count);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // watchdog
  // --------------------------------------------------------------------------
  int unsigned cycle_cnt;

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  function automatic text_t rand_text();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_text(input text_t fill, input bit randomize,
                                     input int unsigned count, input bit restart);
    in_item_t it;
    for (int w = 0; w < NUM_TEXT; w++) it.text_word[w] = randomize ? rand_text() : fill;
    it.byte_count = count_t'(count);
    it.restart    = restart;
    pending_text_q.push_back(it);
  endfunction

  // one register write; the shadow copy follows at the handshake
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t d);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(negedge clk_i); while (!cfg_took);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_KEY_01:   key_reg[0]   = d;
      CFG_KEY_23:   key_reg[1]   = d;
      CFG_KEY_45:   key_reg[2]   = d;
      CFG_KEY_67:   key_reg[3]   = d;
      CFG_NONCE_01: nonce01_reg  = d;
      CFG_NONCE_2:  nonce2_reg   = d[31:0];
      CFG_INIT_CTR: init_ctr_reg = d[31:0];
      default:      ;
    endcase
  endtask

  task automatic program_cipher(input cfg_data_t k01, input cfg_data_t k23,
                                input cfg_data_t k45, input cfg_data_t k67,
                                input cfg_data_t n01, input cfg_data_t n2,
                                input cfg_data_t ctr);
    // stray write to the empty index now and then, it must change nothing
    if ($urandom_range(0, 1) == 0) write_reg(CFG_UNUSED, {$urandom, $urandom});
    write_reg(CFG_KEY_01, k01);
    write_reg(CFG_KEY_23, k23);
    write_reg(CFG_KEY_45, k45);
    write_reg(CFG_KEY_67, k67);
    write_reg(CFG_NONCE_01, n01);
    write_reg(CFG_NONCE_2, n2);
    write_reg(CFG_INIT_CTR, ctr);
  endtask

  // sender pauses until every expected result is back, then lets the core settle
  task automatic drain();
    while (pending_text_q.size() > 0 || in_if.valid || expected_cipher_q.size() > 0)
      @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  int unsigned n_items;
  int unsigned msg_len;
  setting_e    setting;

  initial begin
    mismatches   = 0;
    hold_req     = 0;
    hold_seen    = 0;
    hold_left    = 0;
    rx_mode_left = 0;
    burst_left   = 0;
    gap_left     = 0;
    in_took      = 1'b0;
    cfg_took     = 1'b0;
    for (int i = 0; i < 4; i++) key_reg[i] = '0;
    nonce01_reg  = '0;
    nonce2_reg   = '0;
    init_ctr_reg = '0;
    blk_ctr      = '0;

    rst_ni           = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = '0;
    cfg_if.data      = '0;
    in_if.valid      = 1'b0;
    in_if.text_word_0 = '0;
    in_if.text_word_1 = '0;
    in_if.text_word_2 = '0;
    in_if.text_word_3 = '0;
    in_if.text_word_4 = '0;
    in_if.text_word_5 = '0;
    in_if.text_word_6 = '0;
    in_if.text_word_7 = '0;
    in_if.byte_count = '0;
    in_if.restart    = 1'b0;
    out_if.ready     = 1'b0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // registers at reset value, counter starts at zero without restart
    queue_text('0, 1'b0, FULL_BLOCK, 1'b0);
    queue_text('1, 1'b0, FULL_BLOCK, 1'b0);
    // zero byte count: all bytes come out zero, counter still advances
    queue_text('1, 1'b0, 0, 1'b0);
    queue_text('0, 1'b1, 1, 1'b0);
    queue_text('0, 1'b1, 8, 1'b0);
    queue_text('0, 1'b1, 9, 1'b0);
    queue_text('1, 1'b0, 63, 1'b1);
    // counts above a full block keep all 64 bytes
    queue_text('0, 1'b1, 65, 1'b0);
    queue_text('1, 1'b0, 127, 1'b0);
    drain();

    // all-ones setting with the counter about to wrap
    program_cipher('1, '1, '1, '1, '1, '1, 64'hFFFF_FFFF_FFFF_FFFE);
    write_reg(CFG_UNUSED, '1);
    queue_text('0, 1'b1, FULL_BLOCK, 1'b1);
    queue_text('0, 1'b1, FULL_BLOCK, 1'b0);
    // counter wraps to zero here, nonce stays untouched
    queue_text('0, 1'b1, 100, 1'b0);
    queue_text('0, 1'b1, 31, 1'b0);
    queue_text('1, 1'b0, 7, 1'b0);
    drain();

    // well-known key/nonce pattern, junk in the unused upper halves
    program_cipher(64'h0706_0504_0302_0100, 64'h0f0e_0d0c_0b0a_0908,
                   64'h1716_1514_1312_1110, 64'h1f1e_1d1c_1b1a_1918,
                   64'h4a00_0000_0000_0000, 64'hDEAD_BEEF_0000_0000,
                   64'hCAFE_F00D_0000_0001);
    queue_text('0, 1'b1, FULL_BLOCK, 1'b1);
    queue_text('0, 1'b1, FULL_BLOCK, 1'b0);
    queue_text('0, 1'b1, 50, 1'b0);
    queue_text('0, 1'b1, FULL_BLOCK, 1'b1);
    drain();

    // random phases, each reprogramming the registers with a setting chosen by phase number
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      setting = setting_e'(ph % 4);
      case (setting)
        SET_ZEROS: program_cipher('0, '0, '0, '0, '0, '0, '0);
        SET_ONES:  program_cipher('1, '1, '1, '1, '1, '1, '1);
        SET_WRAP:  program_cipher(rand_text(), rand_text(), rand_text(), rand_text(),
                                  rand_text(), rand_text(),
                                  {$urandom, 32'hFFFF_FFF0 | 32'($urandom_range(0, 15))});
        default:   program_cipher(rand_text(), rand_text(), rand_text(), rand_text(),
                                  rand_text(), rand_text(), rand_text());
      endcase
      // one phase runs against a long receiver hold-off
      if (ph == 2) hold_req++;
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: any count, any restart
          queue_text('0, 1'b1, $urandom_range(0, 127), $urandom_range(0, 1));
          n_items++;
        end else begin
          // a message: restart on the first block, full blocks, a last block of 1 to 64 bytes
          msg_len = $urandom_range(1, 12);
          for (int b = 0; b < msg_len; b++) begin
            queue_text('0, 1'b1,
                       (b == msg_len - 1) ? $urandom_range(1, FULL_BLOCK) : FULL_BLOCK,
                       b == 0);
          end
          n_items += msg_len;
        end
        // keep the feed ahead of the driver without piling everything up
        while (pending_text_q.size() > 64) @(negedge clk_i);
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- chacha20_stream_cipher_core.f -----
rtl/core/cc20_pkg.sv
rtl/core/cc20_ifs.sv
rtl/core/cc20_qr.sv
rtl/core/cc20_ctrl.sv
rtl/core/cc20_datapath.sv
rtl/core/chacha20_stream_cipher_core.sv
rtl/core/cc20_checker.sv
tb/tb.sv
